// File: hw/rtl/pmic_regulator_register_file_core_macros.svh
// Assertion macros shared by the register file RTL.
// Included by the controller and datapath; no other dependencies.
`ifndef PMIC_REGULATOR_REGISTER_FILE_CORE_MACROS_SVH
`define PMIC_REGULATOR_REGISTER_FILE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define PRF_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define PRF_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);
`else
`define PRF_ASSERT_IMPL(label, clk, rst, lhs, rhs, msg)
`define PRF_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg)
`endif

`endif

// File: hw/rtl/prf_pkg.sv
// Package for the regulator register file: widths, register map constants,
// controller state type and controller-to-datapath command struct. No dependencies.
`default_nettype none

package prf_pkg;

  localparam int REGISTER_COUNT_DEFAULT = 256;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int NIB_W   = 4;
  localparam int VOLT_W  = 22;
  localparam int STEP_W  = 15;
  localparam int PROD_W  = DATA_W + STEP_W;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_ENABLE_END = 16'h0006;
  localparam logic [ADDR_W-1:0] ADDR_CHIP_NAME  = 16'h005a;
  localparam logic [ADDR_W-1:0] ADDR_CHIP_VER   = 16'h005b;
  localparam logic [ADDR_W-1:0] ADDR_SYS_CFG    = 16'h0072;
  localparam logic [ADDR_W-1:0] BUCK_FIRST      = 16'h001a;
  localparam logic [ADDR_W-1:0] BUCK_END        = 16'h0024;
  localparam logic [ADDR_W-1:0] NLDO_FIRST      = 16'h0043;
  localparam logic [ADDR_W-1:0] NLDO_END        = 16'h0048;
  localparam logic [ADDR_W-1:0] PLDO_FIRST      = 16'h004e;
  localparam logic [ADDR_W-1:0] PLDO_END        = 16'h0054;

  localparam logic [DATA_W-1:0] CHIP_NAME_VALUE = 8'h80;
  localparam logic [NIB_W-1:0]  CHIP_VER_HIGH   = 4'h6;

  localparam logic [DATA_W-1:0] BUCK_FINE_END   = 8'd160;
  localparam logic [DATA_W-1:0] BUCK_COARSE_END = 8'd237;
  localparam logic [DATA_W-1:0] LDO_END_SEL     = 8'd232;

  localparam logic [VOLT_W-1:0] UV_BASE_LOW   = 22'd500000;
  localparam logic [VOLT_W-1:0] UV_BASE_HIGH  = 22'd1500000;
  localparam logic [VOLT_W-1:0] UV_FLAT       = 22'd3400000;
  localparam logic [STEP_W-1:0] UV_STEP_BUCK_FINE   = 15'd6250;
  localparam logic [STEP_W-1:0] UV_STEP_BUCK_COARSE = 15'd25000;
  localparam logic [STEP_W-1:0] UV_STEP_LDO         = 15'd12500;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/prf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none

module prf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/prf_ctrl.sv
// Controller for the register file: accept, execute, output valid tracking.
// Depends on prf_pkg and the assertion macro header.
`default_nettype none
`include "pmic_regulator_register_file_core_macros.svh"

module prf_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output prf_pkg::ctrl_cmd_t     cmd
);

  prf_pkg::state_t state, state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prf_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      prf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = prf_pkg::ST_EXEC;
        end
      end
      prf_pkg::ST_EXEC: begin
        // hold until the output register is free
        if (!out_valid || out_ready) begin
          cmd.execute = 1'b1;
          state_next  = prf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prf_pkg::ST_IDLE;
      end
    endcase

    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  `PRF_ASSERT_NEXT(a_capture_to_exec, clk, rst, cmd.capture, state == prf_pkg::ST_EXEC, "capture did not enter execute")
  `PRF_ASSERT_NEXT(a_execute_sets_valid, clk, rst, cmd.execute, out_valid, "execute did not raise out_valid")
  `PRF_ASSERT_IMPL(a_no_overwrite, clk, rst, cmd.execute, !out_valid || out_ready, "execute over a pending result")

endmodule

`default_nettype wire

// File: hw/rtl/prf_datapath.sv
// Datapath for the register file: input capture, register store with valid
// bits, masked write, identity readback, voltage decode and output register.
// Depends on prf_pkg, prf_ram and the assertion macro header.
`default_nettype none
`include "pmic_regulator_register_file_core_macros.svh"

module prf_datapath #(
  parameter int REGISTER_COUNT = prf_pkg::REGISTER_COUNT_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire prf_pkg::ctrl_cmd_t           cmd,
  input  wire logic                         cfg_write_enable,
  input  wire logic [prf_pkg::NIB_W-1:0]    cfg_write_data,
  input  wire logic                         operation,
  input  wire logic [prf_pkg::ADDR_W-1:0]   reg_address,
  input  wire logic [prf_pkg::DATA_W-1:0]   write_data,
  output logic      [prf_pkg::DATA_W-1:0]   read_data,
  output logic                              is_voltage_register,
  output logic      [prf_pkg::VOLT_W-1:0]   voltage_uv,
  output logic                              power_off,
  output logic                              access_error
);

  localparam int AW = $clog2(REGISTER_COUNT);
  localparam logic [prf_pkg::ADDR_W-1:0] REG_LIMIT = prf_pkg::ADDR_W'(REGISTER_COUNT);

  logic                          op_q;
  logic [prf_pkg::ADDR_W-1:0]    addr_q;
  logic [prf_pkg::DATA_W-1:0]    data_q;
  logic [prf_pkg::NIB_W-1:0]     chip_version_nibble;
  logic [REGISTER_COUNT-1:0]     valid;
  logic                          sys_off;

  logic [prf_pkg::DATA_W-1:0]    ram_rdata;
  logic [prf_pkg::DATA_W-1:0]    old_byte;
  logic [prf_pkg::DATA_W-1:0]    new_byte;
  logic [prf_pkg::DATA_W-1:0]    rd_byte;
  logic [prf_pkg::NIB_W-1:0]     mask;
  logic                          in_range, is_ident, is_enable, is_buck, is_ldo;
  logic                          wr_en, err, off_next;
  logic [prf_pkg::VOLT_W-1:0]    base;
  logic [prf_pkg::STEP_W-1:0]    step;
  logic [prf_pkg::DATA_W-1:0]    k;
  logic [prf_pkg::PROD_W-1:0]    product;
  logic [prf_pkg::VOLT_W-1:0]    volt;

  prf_ram #(
    .WIDTH (prf_pkg::DATA_W),
    .DEPTH (REGISTER_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr_q[AW-1:0]),
    .wdata (new_byte),
    .re    (cmd.capture),
    .raddr (reg_address[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= operation;
      addr_q <= reg_address;
      data_q <= write_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_version_nibble <= '0;
      valid               <= '0;
      sys_off             <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        chip_version_nibble <= cfg_write_data;
      end
      if (wr_en) begin
        valid[addr_q[AW-1:0]] <= 1'b1;
      end
      if (cmd.execute) begin
        sys_off <= off_next;
      end
    end
  end

  always_comb begin
    in_range  = addr_q < REG_LIMIT;
    is_ident  = (addr_q == prf_pkg::ADDR_CHIP_NAME) || (addr_q == prf_pkg::ADDR_CHIP_VER);
    is_enable = addr_q < prf_pkg::ADDR_ENABLE_END;
    is_buck   = in_range && (addr_q >= prf_pkg::BUCK_FIRST) && (addr_q < prf_pkg::BUCK_END);
    is_ldo    = in_range &&
                (((addr_q >= prf_pkg::NLDO_FIRST) && (addr_q < prf_pkg::NLDO_END)) ||
                 ((addr_q >= prf_pkg::PLDO_FIRST) && (addr_q < prf_pkg::PLDO_END)));

    // never-written entries read as their reset value
    old_byte = valid[addr_q[AW-1:0]] ? ram_rdata : '0;
    mask     = data_q[prf_pkg::DATA_W-1:prf_pkg::NIB_W];

    if (op_q == prf_pkg::OP_WRITE && in_range && !is_ident) begin
      if (is_enable) begin
        new_byte = {{(prf_pkg::DATA_W-prf_pkg::NIB_W){1'b0}},
                    (old_byte[prf_pkg::NIB_W-1:0] & ~mask) |
                    (data_q[prf_pkg::NIB_W-1:0] & mask)};
      end else begin
        new_byte = data_q;
      end
    end else begin
      new_byte = old_byte;
    end

    wr_en = cmd.execute && (op_q == prf_pkg::OP_WRITE) && in_range && !is_ident;
    err   = (op_q == prf_pkg::OP_WRITE) && in_range && is_ident;

    if (op_q == prf_pkg::OP_WRITE || !in_range) begin
      rd_byte = '0;
    end else if (addr_q == prf_pkg::ADDR_CHIP_NAME) begin
      rd_byte = prf_pkg::CHIP_NAME_VALUE;
    end else if (addr_q == prf_pkg::ADDR_CHIP_VER) begin
      rd_byte = {prf_pkg::CHIP_VER_HIGH, chip_version_nibble};
    end else if (is_enable) begin
      rd_byte = {{(prf_pkg::DATA_W-prf_pkg::NIB_W){1'b0}}, old_byte[prf_pkg::NIB_W-1:0]};
    end else begin
      rd_byte = old_byte;
    end

    // pick one linear segment, then base + step * k
    base = '0;
    step = '0;
    k    = '0;
    if (is_buck) begin
      if (new_byte < prf_pkg::BUCK_FINE_END) begin
        base = prf_pkg::UV_BASE_LOW;
        step = prf_pkg::UV_STEP_BUCK_FINE;
        k    = new_byte;
      end else if (new_byte < prf_pkg::BUCK_COARSE_END) begin
        base = prf_pkg::UV_BASE_HIGH;
        step = prf_pkg::UV_STEP_BUCK_COARSE;
        k    = new_byte - prf_pkg::BUCK_FINE_END;
      end else begin
        base = prf_pkg::UV_FLAT;
      end
    end else if (is_ldo) begin
      if (new_byte < prf_pkg::LDO_END_SEL) begin
        base = prf_pkg::UV_BASE_LOW;
        step = prf_pkg::UV_STEP_LDO;
        k    = new_byte;
      end else begin
        base = prf_pkg::UV_FLAT;
      end
    end
    product = prf_pkg::PROD_W'(k) * prf_pkg::PROD_W'(step);
    volt    = base + product[prf_pkg::VOLT_W-1:0];

    if (wr_en && addr_q == prf_pkg::ADDR_SYS_CFG) begin
      off_next = data_q[0];
    end else begin
      off_next = sys_off;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      read_data           <= rd_byte;
      is_voltage_register <= is_buck || is_ldo;
      voltage_uv          <= volt;
      power_off           <= off_next;
      access_error        <= err;
    end
  end

  `PRF_ASSERT_NEXT(a_write_reads_zero, clk, rst,
    cmd.execute && op_q == prf_pkg::OP_WRITE, read_data == '0,
    "write returned nonzero read data")
  `PRF_ASSERT_NEXT(a_out_of_range_quiet, clk, rst, cmd.execute && !in_range,
    read_data == '0 && !is_voltage_register && !access_error,
    "out-of-range access had an effect")
  `PRF_ASSERT_IMPL(a_ident_never_written, clk, rst, wr_en, !is_ident && in_range,
    "write reached a read-only or absent register")

endmodule

`default_nettype wire

// File: hw/rtl/pmic_regulator_register_file_core.sv
// Power-management register file: single-byte read/write accesses.
//
// Input channel (in_valid/in_ready) carries one access: operation (0 read,
// 1 write), reg_address and write_data. Output channel (out_valid/out_ready)
// returns one result per access: read_data, is_voltage_register, voltage_uv,
// power_off and access_error.
// cfg_write_enable/cfg_write_data load the chip version nibble.
//
// out_valid is registered. An accepted access is captured, its register store
// read is registered, then the execute step writes back and decodes; a new
// access is taken only after the last one has left the execute step.
// A finished result sits in the output register; the next access is taken
// meanwhile and waits in the execute step until the receiver takes the
// pending result, so a stalled receiver holds the pending result and at most one more access.
// Reset clears the configuration, the power-off bit and one valid bit per
// register entry at once; unwritten entries read as zero, so there is no
// clearing pass and the block accepts from the first cycle after reset.
// Depends on prf_pkg, prf_ctrl and prf_datapath.
`default_nettype none

module pmic_regulator_register_file_core #(
  parameter int REGISTER_COUNT = prf_pkg::REGISTER_COUNT_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write_enable,
  input  wire logic [prf_pkg::NIB_W-1:0]    cfg_write_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         operation,
  input  wire logic [prf_pkg::ADDR_W-1:0]   reg_address,
  input  wire logic [prf_pkg::DATA_W-1:0]   write_data,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic      [prf_pkg::DATA_W-1:0]   read_data,
  output logic                              is_voltage_register,
  output logic      [prf_pkg::VOLT_W-1:0]   voltage_uv,
  output logic                              power_off,
  output logic                              access_error
);

  prf_pkg::ctrl_cmd_t cmd;

  prf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  prf_datapath #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_datapath (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_write_data      (cfg_write_data),
    .operation           (operation),
    .reg_address         (reg_address),
    .write_data          (write_data),
    .read_data           (read_data),
    .is_voltage_register (is_voltage_register),
    .voltage_uv          (voltage_uv),
    .power_off           (power_off),
    .access_error        (access_error)
  );

endmodule

`default_nettype wire

// File: verif/prf_access_checker.sv
// Checker for the regulator register file: watches both channels, predicts each
// access result from its own register image and compares field by field.
// Depends on prf_pkg for widths and register map constants.
module prf_access_checker
  import prf_pkg::*;
#(
  parameter int REGISTER_COUNT = REGISTER_COUNT_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_enable,
  input  logic [NIB_W-1:0]  cfg_write_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic              operation,
  input  logic [ADDR_W-1:0] reg_address,
  input  logic [DATA_W-1:0] write_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DATA_W-1:0] read_data,
  input  logic              is_voltage_register,
  input  logic [VOLT_W-1:0] voltage_uv,
  input  logic              power_off,
  input  logic              access_error,
  output int                outstanding,
  output int                mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DATA_W-1:0] rd;
    logic              isv;
    logic [VOLT_W-1:0] volt;
    logic              off;
    logic              err;
  } access_result_t;

  access_result_t    predicted_results[$];
  access_result_t    oldest_result;
  logic [DATA_W-1:0] reg_image[REGISTER_COUNT];
  logic [NIB_W-1:0]  version_nibble;

  function automatic logic [VOLT_W-1:0] selector_microvolts(logic buck, logic [DATA_W-1:0] s);
    int unsigned code;
    code = s;
    if (buck) begin
      if (code < BUCK_FINE_END) return 500000 + 6250 * code;
      if (code < BUCK_COARSE_END) return 1500000 + 25000 * (code - BUCK_FINE_END);
      return 3400000;
    end
    if (code < LDO_END_SEL) return 500000 + 12500 * code;
    return 3400000;
  endfunction

  // Apply one access to the register image and return what the block must report.
  function automatic access_result_t predict_access(logic op, logic [ADDR_W-1:0] addr,
                                                    logic [DATA_W-1:0] data);
    access_result_t  res;
    logic [NIB_W-1:0] mask;
    logic            ident;
    logic            buck;
    logic            ldo;
    res = '0;
    if (addr < REGISTER_COUNT) begin
      ident = (addr == ADDR_CHIP_NAME) || (addr == ADDR_CHIP_VER);
      buck  = (addr >= BUCK_FIRST) && (addr < BUCK_END);
      ldo   = ((addr >= NLDO_FIRST) && (addr < NLDO_END)) ||
              ((addr >= PLDO_FIRST) && (addr < PLDO_END));
      if (op == OP_WRITE) begin
        if (ident) begin
          res.err = 1'b1;
        end else if (addr < ADDR_ENABLE_END) begin
          // upper nibble of the data masks the lower nibble bit by bit
          mask = data[7:4];
          reg_image[addr] = {4'h0, (reg_image[addr][3:0] & ~mask) | (data[3:0] & mask)};
        end else begin
          reg_image[addr] = data;
        end
      end else begin
        if (addr == ADDR_CHIP_NAME) res.rd = CHIP_NAME_VALUE;
        else if (addr == ADDR_CHIP_VER) res.rd = {CHIP_VER_HIGH, version_nibble};
        else if (addr < ADDR_ENABLE_END) res.rd = {4'h0, reg_image[addr][3:0]};
        else res.rd = reg_image[addr];
      end
      if (buck || ldo) begin
        res.isv  = 1'b1;
        res.volt = selector_microvolts(buck, reg_image[addr]);
      end
    end
    res.off = reg_image[ADDR_SYS_CFG][0];
    return res;
  endfunction

  task automatic check_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (reg_image[i]) reg_image[i] = '0;
      version_nibble = '0;
      predicted_results.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_write_enable) version_nibble = cfg_write_data;
      // retire before admitting: a result never belongs to the access taken at the same edge
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result transaction with no access outstanding");
          mismatch_count++;
        end else begin
          oldest_result = predicted_results.pop_front();
          check_field("read_data", oldest_result.rd, read_data);
          check_field("is_voltage_register", oldest_result.isv, is_voltage_register);
          check_field("voltage_uv", oldest_result.volt, voltage_uv);
          check_field("power_off", oldest_result.off, power_off);
          check_field("access_error", oldest_result.err, access_error);
        end
      end
      if (in_valid && in_ready)
        predicted_results.push_back(predict_access(operation, reg_address, write_data));
    end
    outstanding = predicted_results.size();
  end

endmodule

// File: verif/pmic_regulator_register_file_core_tb.sv
// Testbench top for the regulator register file: clock, reset, access stimulus,
// receiver back-pressure and the verdict. Depends on prf_pkg, prf_access_checker
// and the block itself.
module pmic_regulator_register_file_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prf_pkg::*;

  localparam int PHASE_ITEMS = 132;
  localparam int HOLD_CYCLES = 80;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write_enable = 1'b0;
  logic [NIB_W-1:0]  cfg_write_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              operation = OP_READ;
  logic [ADDR_W-1:0] reg_address = '0;
  logic [DATA_W-1:0] write_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] read_data;
  logic              is_voltage_register;
  logic [VOLT_W-1:0] voltage_uv;
  logic              power_off;
  logic              access_error;

  int outstanding;
  int mismatch_count;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  always #1 clk = ~clk;

  pmic_regulator_register_file_core i_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_write_data      (cfg_write_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .operation           (operation),
    .reg_address         (reg_address),
    .write_data          (write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .read_data           (read_data),
    .is_voltage_register (is_voltage_register),
    .voltage_uv          (voltage_uv),
    .power_off           (power_off),
    .access_error        (access_error)
  );

  prf_access_checker i_checker (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write_enable    (cfg_write_enable),
    .cfg_write_data      (cfg_write_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .operation           (operation),
    .reg_address         (reg_address),
    .write_data          (write_data),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .read_data           (read_data),
    .is_voltage_register (is_voltage_register),
    .voltage_uv          (voltage_uv),
    .power_off           (power_off),
    .access_error        (access_error),
    .outstanding         (outstanding),
    .mismatch_count      (mismatch_count)
  );

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left == 0 && hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one access and hold it until the accepting edge.
  task automatic push_access(logic op, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    operation = op;
    reg_address = addr;
    write_data = data;
    do @(posedge clk); while (!in_ready);
  endtask

  // Drop valid, let every result drain, then load the version nibble.
  task automatic program_version(logic [NIB_W-1:0] nibble);
    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    cfg_write_enable = 1'b1;
    cfg_write_data = nibble;
    @(negedge clk);
    cfg_write_enable = 1'b0;
  endtask

  task automatic random_access();
    int unsigned      pick;
    logic [ADDR_W-1:0] addr;
    pick = $urandom_range(99);
    if (pick < 8) addr = $urandom_range(16'hffff);
    else if (pick < 28) addr = $urandom_range(ADDR_ENABLE_END - 1);
    else if (pick < 52) addr = $urandom_range(BUCK_END - 1, BUCK_FIRST);
    else if (pick < 64) addr = $urandom_range(NLDO_END - 1, NLDO_FIRST);
    else if (pick < 76) addr = $urandom_range(PLDO_END - 1, PLDO_FIRST);
    else if (pick < 81) addr = $urandom_range(1) ? ADDR_CHIP_VER : ADDR_CHIP_NAME;
    else if (pick < 86) addr = ADDR_SYS_CFG;
    else addr = $urandom_range(255);
    push_access($urandom_range(1) ? OP_WRITE : OP_READ, addr, $urandom_range(255));
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    program_version(4'hf);

    // identity registers refuse writes
    push_access(OP_WRITE, ADDR_CHIP_NAME, 8'hff);
    push_access(OP_WRITE, ADDR_CHIP_VER, 8'h00);
    push_access(OP_READ, ADDR_CHIP_NAME, 8'h00);
    push_access(OP_READ, ADDR_CHIP_VER, 8'hff);
    // enable registers with masked writes
    push_access(OP_WRITE, 16'h0000, 8'hff);
    push_access(OP_WRITE, 16'h0000, 8'h50);
    push_access(OP_READ, 16'h0000, 8'h00);
    push_access(OP_WRITE, 16'h0005, 8'haf);
    push_access(OP_READ, 16'h0005, 8'h00);
    push_access(OP_WRITE, 16'h0006, 8'hff);
    // selector range edges
    push_access(OP_WRITE, BUCK_FIRST, 8'd159);
    push_access(OP_WRITE, BUCK_END - 1, 8'd160);
    push_access(OP_WRITE, BUCK_FIRST + 1, 8'd236);
    push_access(OP_WRITE, BUCK_FIRST + 2, 8'd237);
    push_access(OP_READ, BUCK_FIRST + 3, 8'h00);
    push_access(OP_WRITE, NLDO_FIRST, 8'd231);
    push_access(OP_WRITE, NLDO_END - 1, 8'd232);
    push_access(OP_WRITE, PLDO_END - 1, 8'd255);
    push_access(OP_READ, BUCK_END, 8'h00);
    // power-off bit and out-of-range addresses
    push_access(OP_WRITE, ADDR_SYS_CFG, 8'h01);
    push_access(OP_READ, ADDR_SYS_CFG, 8'h00);
    push_access(OP_WRITE, 16'h00ff, 8'haa);
    push_access(OP_WRITE, 16'h0100, 8'h55);
    push_access(OP_READ, 16'hffff, 8'h00);
    push_access(OP_WRITE, ADDR_SYS_CFG, 8'hfe);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          program_version(4'h0);
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          program_version($urandom_range(15));
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          program_version(4'hf);
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          program_version(4'h9);
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the receiver off while the sender keeps offering, to fill the block
        if (n == 30 && (phase == 0 || phase == 3)) hold_requests++;
        random_access();
      end
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/prf_pkg.sv
hw/rtl/prf_ram.sv
hw/rtl/prf_ctrl.sv
hw/rtl/prf_datapath.sv
hw/rtl/pmic_regulator_register_file_core.sv
verif/prf_access_checker.sv
verif/pmic_regulator_register_file_core_tb.sv
